// ----- hw/rtl/bpt_pkg.sv -----
`timescale 1ns / 1ps

package bpt_pkg;

  // data widths
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  // attack sum holds peak + 7 * magnitude
  localparam int ATTACK_BITS = SAMPLE_BITS + 4;

  // operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // one accepted input item
  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
  } item_t;

endpackage

// ----- hw/rtl/bpt_in_stage.sv -----
`timescale 1ns / 1ps

module bpt_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [bpt_pkg::SAMPLE_BITS-1:0] in_sample_a,
  input  logic [bpt_pkg::SAMPLE_BITS-1:0] in_sample_b,
  input  logic                           advance,
  output logic                           item_valid,
  output bpt_pkg::item_t                 item
);

  logic           valid_r;
  logic           valid_nxt;
  bpt_pkg::item_t item_r;
  logic           take;

  // stage is free when empty or when its item moves on this cycle
  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.op       <= in_op;
      item_r.sample_a <= in_sample_a;
      item_r.sample_b <= in_sample_b;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/bpt_track.sv -----
`timescale 1ns / 1ps

module bpt_track (
  input  logic [bpt_pkg::SAMPLE_BITS-1:0] peak,
  input  logic [bpt_pkg::SAMPLE_BITS-1:0] mag,
  output logic [bpt_pkg::SAMPLE_BITS-1:0] peak_nxt
);

  localparam int SB = bpt_pkg::SAMPLE_BITS;
  localparam int AB = bpt_pkg::ATTACK_BITS;

  logic [AB-1:0] attack_sum;
  logic [SB-1:0] attack_val;
  logic [SB-1:0] gap;
  logic [SB-1:0] lim;
  logic [SB-1:0] decay;

  // attack: (peak + 8*mag - mag) / 8
  assign attack_sum = {{(AB-SB){1'b0}}, peak}
                    + {1'b0, mag, 3'b000}
                    - {{(AB-SB){1'b0}}, mag};
  assign attack_val = attack_sum[SB+2:3];

  // decay: gap limited to peak / 16
  assign gap   = peak - mag;
  assign lim   = {4'b0000, peak[SB-1:4]};
  assign decay = (gap > lim) ? lim : gap;

  assign peak_nxt = (mag >= peak) ? attack_val : (peak - decay);

endmodule

// ----- hw/rtl/bipolar_peak_tracker.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------
// in_      | input     | in_valid/in_stall  | in_op, in_sample_a, in_sample_b
// out_     | output    | out_valid/out_stall| out_mean_value (signed, 13 bits)
//
// one item per cycle unless out_stall holds a result; a result passes the input
// register, then the tracker update into the result register, before it is valid
// and can transfer out
// peak and count state updates as an item enters the result register
// synchronous active-low reset clears trackers, counters and both valid flags
// out_stall holds the result; the input stage keeps taking items until it is full
module bipolar_peak_tracker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [bpt_pkg::SAMPLE_BITS-1:0]       in_sample_a,
  input  logic [bpt_pkg::SAMPLE_BITS-1:0]       in_sample_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bpt_pkg::OUT_BITS-1:0]   out_mean_value
);

  localparam int SB = bpt_pkg::SAMPLE_BITS;
  localparam int CB = bpt_pkg::COUNT_BITS;
  localparam int OB = bpt_pkg::OUT_BITS;

  logic           item_valid;
  bpt_pkg::item_t item;
  logic           advance;

  logic [SB-1:0] pos_peak_r, pos_peak_nxt;
  logic [SB-1:0] neg_peak_r, neg_peak_nxt;
  logic [CB-1:0] pos_count_r, pos_count_nxt;
  logic [CB-1:0] neg_count_r, neg_count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OB-1:0] mean_r, mean_nxt;

  logic          b_ge_a;
  logic          b_le_a;
  logic [SB-1:0] pos_mag;
  logic [SB-1:0] neg_mag;
  logic [SB-1:0] pos_track;
  logic [SB-1:0] neg_track;

  // input register
  bpt_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .advance     (advance),
    .item_valid  (item_valid),
    .item        (item)
  );

  // item moves on when the result register is empty or being taken
  assign advance = item_valid && (!out_valid_r || !out_stall);

  // polarity and magnitudes of the difference
  assign b_ge_a  = item.sample_b >= item.sample_a;
  assign b_le_a  = item.sample_b <= item.sample_a;
  assign pos_mag = item.sample_b - item.sample_a;
  assign neg_mag = item.sample_a - item.sample_b;

  bpt_track u_pos (
    .peak     (pos_peak_r),
    .mag      (pos_mag),
    .peak_nxt (pos_track)
  );

  bpt_track u_neg (
    .peak     (neg_peak_r),
    .mag      (neg_mag),
    .peak_nxt (neg_track)
  );

  // next tracker and counter state
  always_comb begin
    pos_peak_nxt  = pos_peak_r;
    neg_peak_nxt  = neg_peak_r;
    pos_count_nxt = pos_count_r;
    neg_count_nxt = neg_count_r;
    if (item.op == bpt_pkg::OP_CLEAR) begin
      pos_peak_nxt  = '0;
      neg_peak_nxt  = '0;
      pos_count_nxt = '0;
      neg_count_nxt = '0;
    end else begin
      if (b_ge_a) begin
        pos_peak_nxt  = pos_track;
        pos_count_nxt = (&pos_count_r) ? pos_count_r : pos_count_r + 1'b1;
      end
      if (b_le_a) begin
        neg_peak_nxt  = neg_track;
        neg_count_nxt = (&neg_count_r) ? neg_count_r : neg_count_r + 1'b1;
      end
    end
  end

  // dominant polarity picks the reported peak
  assign mean_nxt = (pos_count_nxt >= neg_count_nxt) ? {1'b0, pos_peak_nxt}
                                                     : ({OB{1'b0}} - {1'b0, neg_peak_nxt});

  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_stall) ? 1'b1 : 1'b0);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_peak_r  <= '0;
      neg_peak_r  <= '0;
      pos_count_r <= '0;
      neg_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        pos_peak_r  <= pos_peak_nxt;
        neg_peak_r  <= neg_peak_nxt;
        pos_count_r <= pos_count_nxt;
        neg_count_r <= neg_count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      mean_r <= mean_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;

endmodule

// ----- dv/bipolar_peak_tracker_test.sv -----
`timescale 1ns / 1ps

module bipolar_peak_tracker_test;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 340;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int ROW_COUNT    = 23;
  localparam int RUN_REPS     = 20;
  localparam int MAX_PRINTS   = 20;
  localparam int SB           = bpt_pkg::SAMPLE_BITS;
  localparam int CB           = bpt_pkg::COUNT_BITS;
  localparam int OB           = bpt_pkg::OUT_BITS;
  localparam int AB           = bpt_pkg::ATTACK_BITS;

  typedef logic [SB-1:0] sample_t;
  typedef logic signed [OB-1:0] level_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    logic        op;
    sample_t     a;
    sample_t     b;
    int unsigned reps;
    bit          typed;
    level_t      want;
  } stim_row_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  logic    in_op;
  sample_t in_sample_a;
  sample_t in_sample_b;
  logic    out_valid;
  logic    out_stall;
  level_t  out_mean_value;

  // predictor state
  sample_t       pos_peak;
  sample_t       neg_peak;
  logic [CB-1:0] pos_count;
  logic [CB-1:0] neg_count;

  level_t expected_levels[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned random_sent;
  bit          no_idle;
  bit          hold_active;
  bit          long_hold_done;
  bit          send_burst;
  bit          recv_burst;

  bipolar_peak_tracker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_sample_a    (in_sample_a),
    .in_sample_b    (in_sample_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_value (out_mean_value)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bipolar_peak_tracker test failed");
      $finish;
    end
  end

  // attack fast towards a larger magnitude, else decay by at most a sixteenth
  function automatic sample_t peak_follow(input sample_t peak, input sample_t mag);
    logic [AB-1:0] sum;
    sample_t       drop;
    sample_t       cap;
    if (mag >= peak) begin
      sum = {4'b0, peak} + AB'(7) * {4'b0, mag};
      return sample_t'(sum >> 3);
    end
    drop = peak - mag;
    cap  = peak >> 4;
    if (drop > cap)
      drop = cap;
    return peak - drop;
  endfunction

  function automatic logic [CB-1:0] count_bump(input logic [CB-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // advance the predictor by one item and give the level it reports
  task automatic track_pair(input logic op, input sample_t a, input sample_t b,
                            output level_t level);
    if (op == bpt_pkg::OP_CLEAR) begin
      pos_peak  = '0;
      neg_peak  = '0;
      pos_count = '0;
      neg_count = '0;
    end else begin
      if (b >= a) begin
        pos_count = count_bump(pos_count);
        pos_peak  = peak_follow(pos_peak, b - a);
      end
      if (b <= a) begin
        neg_count = count_bump(neg_count);
        neg_peak  = peak_follow(neg_peak, a - b);
      end
    end
    if (pos_count >= neg_count)
      level = {1'b0, pos_peak};
    else
      level = -{1'b0, neg_peak};
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // offer one item from a falling edge, hold it until the transfer, return at a falling edge
  task automatic drive_item(input logic op, input sample_t a, input sample_t b,
                            input bit typed, input level_t want);
    int unsigned gap;
    level_t      level;
    if ($urandom_range(0, 19) == 0)
      send_burst = ~send_burst;
    gap = (send_burst || no_idle || hold_active) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_sample_a <= a;
    in_sample_b <= b;
    do @(posedge clk); while (in_stall);
    track_pair(op, a, b, level);
    expected_levels.push_back(typed ? want : level);
    items_sent++;
    if (op == bpt_pkg::OP_CLEAR)
      clears_sent++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_mean_value));
      end else begin
        if (out_mean_value !== expected_levels[0])
          report_mismatch($sformatf("mean_value %0d, expected %0d",
                                    out_mean_value, expected_levels[0]));
        void'(expected_levels.pop_front());
      end
      results_checked++;
    end
  end

  // receiver: random hold-off per result, one long hold-off during the random part
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (random_sent >= 100 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_active    = 1'b1;
        hold           = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 19) == 0)
          recv_burst = ~recv_burst;
        hold = (recv_burst || no_idle) ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      hold_active = 1'b0;
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    stim_row_t directed_rows [ROW_COUNT];
    logic      op;
    sample_t   a;
    sample_t   b;
    int        swing;
    int        step;
    level_t    reset_level;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = bpt_pkg::OP_ADD;
    in_sample_a = '0;
    in_sample_b = '0;
    cycle_count = 0;
    swing       = 0;

    directed_rows = '{
      // zero difference straight after reset
      '{bpt_pkg::OP_ADD,   12'd0,    12'd0,    1,        1'b1, 13'sd0},
      // full-scale positive attack, then again at the peak
      '{bpt_pkg::OP_ADD,   12'd0,    12'd4095, 1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd0,    12'd4095, 1,        1'b0, 13'sd0},
      // full-scale negative: the positive count still leads, then counts tie
      '{bpt_pkg::OP_ADD,   12'd4095, 12'd0,    1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd4095, 12'd0,    1,        1'b0, 13'sd0},
      // zero difference decays both trackers
      '{bpt_pkg::OP_ADD,   12'd100,  12'd100,  1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd0,    12'd4000, 1,        1'b0, 13'sd0},
      // decay capped at peak/16, then a positive attack
      '{bpt_pkg::OP_ADD,   12'd2000, 12'd2100, 1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd0,    12'd3900, 1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_CLEAR, 12'd4095, 12'd4095, 1,        1'b1, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd4095, 12'd0,    1,        1'b1, -13'sd3583},
      '{bpt_pkg::OP_CLEAR, 12'd0,    12'd0,    1,        1'b1, 13'sd0},
      // long positive run overtakes a small negative count
      '{bpt_pkg::OP_ADD,   12'd1,    12'd0,    5,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd0,    12'd1,    RUN_REPS, 1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd0,    12'd4095, 1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_CLEAR, 12'd0,    12'd0,    1,        1'b1, 13'sd0},
      // long negative run overtakes a small positive count
      '{bpt_pkg::OP_ADD,   12'd0,    12'd1,    5,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd1,    12'd0,    RUN_REPS, 1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd4095, 12'd0,    1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_CLEAR, 12'd4095, 12'd0,    1,        1'b1, 13'sd0},
      // tie after clear reports the positive peak
      '{bpt_pkg::OP_ADD,   12'd4095, 12'd4095, 1,        1'b1, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd4094, 12'd4095, 1,        1'b0, 13'sd0},
      '{bpt_pkg::OP_ADD,   12'd2048, 12'd2047, 1,        1'b0, 13'sd0}
    };

    track_pair(bpt_pkg::OP_CLEAR, '0, '0, reset_level);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      no_idle = directed_rows[r].reps > 1;
      repeat (directed_rows[r].reps)
        drive_item(directed_rows[r].op, directed_rows[r].a, directed_rows[r].b,
                   directed_rows[r].typed, directed_rows[r].want);
    end
    no_idle = 1'b0;

    // random part: random pairs, noise around equal, extremes, equal samples, sustained levels and clears
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = ($urandom_range(0, 39) == 0) ? bpt_pkg::OP_CLEAR : bpt_pkg::OP_ADD;
      a  = sample_t'($urandom);
      b  = sample_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
        end
        3, 4: begin
          b = a + sample_t'($urandom_range(0, 64)) - sample_t'(32);
        end
        5: begin
          a = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? '1 : '0;
        end
        6: begin
          b = a;
        end
        default: begin
          // slowly wandering difference so peaks settle, then decay
          if ($urandom_range(0, 15) == 0)
            swing = int'($urandom_range(0, 8190)) - 4095;
          step  = int'($urandom_range(0, 8)) - 4;
          swing = swing + step;
          if (swing > 4095)
            swing = 4095;
          if (swing < -4095)
            swing = -4095;
          if (swing >= 0) begin
            a = sample_t'($urandom_range(0, 4095 - swing));
            b = a + sample_t'(swing);
          end else begin
            b = sample_t'($urandom_range(0, 4095 + swing));
            a = b + sample_t'(-swing);
          end
        end
      endcase
      drive_item(op, a, b, 1'b0, '0);
      random_sent++;
    end
    in_valid <= 1'b0;

    // drain
    while (expected_levels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items (%0d clears) and %0d results checked, with long runs of each polarity",
             items_sent, clears_sent, results_checked);
    $display("random gaps on both sides plus one %0d-cycle output hold-off with input backed up",
             LONG_HOLD);
    if (error_count == 0 && expected_levels.size() == 0)
      $display("bipolar_peak_tracker test passed");
    else
      $display("bipolar_peak_tracker test failed");
    $finish;
  end

endmodule

// ----- bipolar_peak_tracker.f -----
hw/rtl/bpt_pkg.sv
hw/rtl/bpt_in_stage.sv
hw/rtl/bpt_track.sv
hw/rtl/bipolar_peak_tracker.sv
dv/bipolar_peak_tracker_test.sv
